### rtl/bqd_pkg.sv
// ---------------------------------------------------------------------------
// Biquad IIR filter package
// Request codes, register indexes and the soft-reset scaling constant.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bqd_pkg;

  // Request kinds carried in the input channel's tuser.
  typedef enum logic [1:0] {
    REQ_FILTER = 2'd0,
    REQ_SOFT   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  // Configuration register indexes.
  localparam int REG_ADDR_BITS = 3;
  typedef logic [REG_ADDR_BITS-1:0] reg_addr_t;

  localparam reg_addr_t REG_COEF_A0    = 3'd0;
  localparam reg_addr_t REG_COEF_A1    = 3'd1;
  localparam reg_addr_t REG_COEF_A2    = 3'd2;
  localparam reg_addr_t REG_COEF_B1    = 3'd3;
  localparam reg_addr_t REG_COEF_B2    = 3'd4;
  localparam reg_addr_t REG_OUT_OFFSET = 3'd5;

  // Soft reset scales every history by SCALE_NUM / 2^SCALE_SHIFT (about 0.9).
  localparam int SCALE_SHIFT = 16;
  localparam logic signed [SCALE_SHIFT:0] SCALE_NUM = 17'sd58982;

  // The y history keeps this many bits beyond the sample width.
  localparam int HIST_EXTRA_BITS = 8;

endpackage

### rtl/biquad_iir_filter.sv
// Latency: a sample transfer loads the input register, and its result is
// loaded into the output register at the next clock edge that finds room there.
// Throughput: one item per cycle unless the output stalls; the five products,
// their sum, rounding and both saturations fit in the single combinational pass
// that closes the history feedback loop. Reset (rst_n, synchronous, active low)
// clears the coefficients, the offset, all four histories and both valid flags.
// ---------------------------------------------------------------------------
// Biquad IIR filter
// Second-order direct form I section with Q.COEF_FRAC_BITS coefficients,
// output offset, output saturation and soft/hard history reset requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_iir_filter
  import bqd_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14,
  localparam int COEF_BITS     = COEF_FRAC_BITS + 4,
  localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int CFG_W         = (COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [DATA_W-1:0]        in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  logic [1:0]               in_tuser,   // [1:0] req_type
  // Result channel.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [DATA_W-1:0]        out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic [0:0]               out_tuser,  // [0] saturated
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [REG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int HIST_BITS = SAMPLE_BITS + HIST_EXTRA_BITS;
  localparam int ACC_W     = COEF_BITS + HIST_BITS + 3;
  localparam int YF_W      = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // Soft-reset scaling of one x history, rounded to nearest, ties up.
  function automatic logic signed [SAMPLE_BITS-1:0] scale_x(
    input logic signed [SAMPLE_BITS-1:0] h
  );
    logic signed [SAMPLE_BITS+SCALE_SHIFT:0] p;
    p = h * SCALE_NUM + ((SAMPLE_BITS + SCALE_SHIFT + 1)'(1) << (SCALE_SHIFT - 1));
    return p[SAMPLE_BITS+SCALE_SHIFT-1:SCALE_SHIFT];
  endfunction

  // Same scaling for one y history.
  function automatic logic signed [HIST_BITS-1:0] scale_y(
    input logic signed [HIST_BITS-1:0] h
  );
    logic signed [HIST_BITS+SCALE_SHIFT:0] p;
    p = h * SCALE_NUM + ((HIST_BITS + SCALE_SHIFT + 1)'(1) << (SCALE_SHIFT - 1));
    return p[HIST_BITS+SCALE_SHIFT-1:SCALE_SHIFT];
  endfunction

  // Configuration registers.
  logic signed [COEF_BITS-1:0]   coef_a0_r, coef_a1_r, coef_a2_r, coef_b1_r, coef_b2_r;
  logic signed [SAMPLE_BITS-1:0] out_offset_r;

  // Filter state.
  logic signed [SAMPLE_BITS-1:0] x_hist_1_r, x_hist_2_r;
  logic signed [HIST_BITS-1:0]   y_hist_1_r, y_hist_2_r;

  // Input register.
  logic                          s1_valid_r;
  req_t                          s1_req_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;

  // Output register.
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;
  logic                          out_sat_r;

  // Datapath.
  logic                                  s1_go;
  logic signed [COEF_BITS+SAMPLE_BITS-1:0] prod_a0, prod_a1, prod_a2;
  logic signed [COEF_BITS+HIST_BITS-1:0]   prod_b1, prod_b2;
  logic signed [ACC_W-1:0]               acc, acc_rnd;
  logic signed [YF_W-1:0]                y_full;
  logic                                  y_ovf;
  logic signed [HIST_BITS-1:0]           y_sat;
  logic signed [HIST_BITS:0]             o_full;
  logic                                  o_ovf;
  logic signed [SAMPLE_BITS-1:0]         o_sat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a0_r    <= '0;
      coef_a1_r    <= '0;
      coef_a2_r    <= '0;
      coef_b1_r    <= '0;
      coef_b2_r    <= '0;
      out_offset_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_COEF_A0:    coef_a0_r    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_A1:    coef_a1_r    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_A2:    coef_a2_r    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_B1:    coef_b1_r    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_B2:    coef_b2_r    <= cfg_data[COEF_BITS-1:0];
        REG_OUT_OFFSET: out_offset_r <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the output register has room.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r    <= req_t'(in_tuser);
      s1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Products and their sum.
  always_comb begin
    prod_a0 = coef_a0_r * s1_sample_r;
    prod_a1 = coef_a1_r * x_hist_1_r;
    prod_a2 = coef_a2_r * x_hist_2_r;
    prod_b1 = coef_b1_r * y_hist_1_r;
    prod_b2 = coef_b2_r * y_hist_2_r;
    acc     = ACC_W'(prod_a0) + ACC_W'(prod_a1) + ACC_W'(prod_a2)
            - ACC_W'(prod_b1) - ACC_W'(prod_b2);
  end

  // Round to sample scale, then saturate to the history width.
  always_comb begin
    acc_rnd = acc + ACC_RND;
    y_full  = acc_rnd[ACC_W-1:COEF_FRAC_BITS];
    y_ovf   = (y_full[YF_W-1:HIST_BITS-1] != '0) && (y_full[YF_W-1:HIST_BITS-1] != '1);
    if (y_ovf) begin
      y_sat = {y_full[YF_W-1], {(HIST_BITS-1){~y_full[YF_W-1]}}};
    end else begin
      y_sat = y_full[HIST_BITS-1:0];
    end
  end

  // Add the offset and saturate to the sample width.
  always_comb begin
    o_full = (HIST_BITS + 1)'(y_sat) + (HIST_BITS + 1)'(out_offset_r);
    o_ovf  = (o_full[HIST_BITS:SAMPLE_BITS-1] != '0) &&
             (o_full[HIST_BITS:SAMPLE_BITS-1] != '1);
    if (o_ovf) begin
      o_sat = {o_full[HIST_BITS], {(SAMPLE_BITS-1){~o_full[HIST_BITS]}}};
    end else begin
      o_sat = o_full[SAMPLE_BITS-1:0];
    end
  end

  // History update for each request kind; unused codes leave state alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_hist_1_r <= '0;
      x_hist_2_r <= '0;
      y_hist_1_r <= '0;
      y_hist_2_r <= '0;
    end else if (s1_go) begin
      unique case (s1_req_r)
        REQ_FILTER: begin
          x_hist_2_r <= x_hist_1_r;
          x_hist_1_r <= s1_sample_r;
          y_hist_2_r <= y_hist_1_r;
          y_hist_1_r <= y_sat;
        end
        REQ_SOFT: begin
          x_hist_1_r <= scale_x(x_hist_1_r);
          x_hist_2_r <= scale_x(x_hist_2_r);
          y_hist_1_r <= scale_y(y_hist_1_r);
          y_hist_2_r <= scale_y(y_hist_2_r);
        end
        REQ_CLEAR: begin
          x_hist_1_r <= '0;
          x_hist_2_r <= '0;
          y_hist_1_r <= '0;
          y_hist_2_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register: only a filter request produces a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= (s1_req_r == REQ_FILTER);
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_req_r == REQ_FILTER)) begin
      out_sample_r <= o_sat;
      out_sat_r    <= y_ovf || o_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_sample_r);
  assign out_tuser  = out_sat_r;

endmodule

### test/biquad_iir_filter_tb.sv
// ---------------------------------------------------------------------------
// Biquad IIR filter testbench
// Drives filter samples, soft resets, hard clears and unused request codes
// through the input stream under several coefficient sets. A transaction-level
// predictor in the testbench computes every expected output sample and
// saturation flag, and a monitor compares each result transfer against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_iir_filter_tb
  import bqd_pkg::*;
();

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 4;
  localparam int HIST_BITS      = SAMPLE_BITS + HIST_EXTRA_BITS;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 210;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Register indexes with no register behind them.
  localparam reg_addr_t REG_UNMAPPED_LO = 3'd6;
  localparam reg_addr_t REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] sample;
  } filt_req_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   sat;
  } filt_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [SAMPLE_BITS-1:0]   in_tdata = '0;
  logic [1:0]               in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [SAMPLE_BITS-1:0]   out_tdata;
  logic [0:0]               out_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [REG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [COEF_BITS-1:0]     cfg_data = '0;

  filt_req_t    pending_reqs[$];
  filt_result_t expected_outputs[$];

  // Predictor copy of the registers and the four histories.
  longint coef_q [0:5];
  longint x_prev1 = 0, x_prev2 = 0, y_prev1 = 0, y_prev2 = 0;

  int  mismatches = 0;
  int  src_idle_pct = 0;
  int  sink_idle_pct = 0;
  bit  in_fire = 1'b0;
  bit  long_hold_pending = 1'b0;
  bit  long_hold_done = 1'b0;
  int  hold_left = 0;

  biquad_iir_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round to nearest with ties toward plus infinity, then drop s bits.
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_to(input longint v, input int w, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint scale_down(input longint h);
    return round_half_up(h * longint'(SCALE_NUM), SCALE_SHIFT);
  endfunction

  // Update the predicted histories for one accepted request and queue
  // the expected output when the request is a filter sample.
  task automatic advance_filter(input logic [1:0] kind, input logic [SAMPLE_BITS-1:0] raw);
    longint       x;
    longint       acc;
    longint       y;
    longint       o;
    bit           hit;
    filt_result_t res;
    hit = 1'b0;
    case (kind)
      REQ_SOFT: begin
        x_prev1 = scale_down(x_prev1);
        x_prev2 = scale_down(x_prev2);
        y_prev1 = scale_down(y_prev1);
        y_prev2 = scale_down(y_prev2);
      end
      REQ_CLEAR: begin
        x_prev1 = 0;
        x_prev2 = 0;
        y_prev1 = 0;
        y_prev2 = 0;
      end
      REQ_FILTER: begin
        x   = longint'($signed(raw));
        acc = coef_q[REG_COEF_A0] * x + coef_q[REG_COEF_A1] * x_prev1
            + coef_q[REG_COEF_A2] * x_prev2 - coef_q[REG_COEF_B1] * y_prev1
            - coef_q[REG_COEF_B2] * y_prev2;
        y = clamp_to(round_half_up(acc, COEF_FRAC_BITS), HIST_BITS, hit);
        x_prev2 = x_prev1;
        x_prev1 = x;
        y_prev2 = y_prev1;
        y_prev1 = y;
        o = clamp_to(y + coef_q[REG_OUT_OFFSET], SAMPLE_BITS, hit);
        res.sample = o[SAMPLE_BITS-1:0];
        res.sat    = hit;
        expected_outputs.push_back(res);
      end
      default: begin
        // Unused code: no state change and no result.
      end
    endcase
  endtask

  // Input side: predict on each accepted transfer.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      advance_filter(in_tuser, in_tdata);
    end
  end

  // Sender: offer the next pending request, idling at random between items.
  always @(negedge clk) begin : drive_requests
    filt_req_t nxt;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= nxt.sample;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (long_hold_pending && !long_hold_done) begin
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
      out_tready     <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Result side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    filt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_outputs.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual sample_out=%0d saturated=%0b", $time,
                 $signed(out_tdata), out_tuser[0]);
      end else begin
        want = expected_outputs.pop_front();
        if (out_tdata !== want.sample) begin
          mismatches++;
          $display("%0t: sample_out expected %0d actual %0d", $time,
                   $signed(want.sample), $signed(out_tdata));
        end
        if (out_tuser[0] !== want.sat) begin
          mismatches++;
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                   out_tuser[0]);
        end
      end
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [SAMPLE_BITS-1:0] s);
    filt_req_t r;
    r.kind   = kind;
    r.sample = s;
    pending_reqs.push_back(r);
  endtask

  // One register transfer; the predictor copy follows on acceptance.
  task automatic write_reg(input reg_addr_t idx, input logic [COEF_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_COEF_B2)
      coef_q[idx] = longint'($signed(val));
    else if (idx == REG_OUT_OFFSET)
      coef_q[idx] = longint'($signed(val[SAMPLE_BITS-1:0]));
  endtask

  task automatic load_coefs(input logic [COEF_BITS-1:0] a0, a1, a2, b1, b2,
                            input logic [SAMPLE_BITS-1:0] off);
    write_reg(REG_COEF_A0, a0);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_OUT_OFFSET, {{(COEF_BITS - SAMPLE_BITS){off[SAMPLE_BITS-1]}}, off});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is sent and every result has come back, then
  // give the block time to finish requests that produce no result.
  task automatic settle();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || in_tvalid || expected_outputs.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random coefficient set: stable, fully random, or all at the extremes.
  task automatic random_coefs(input int style);
    int a0, a1, a2, b1, b2, off, lim;
    case (style)
      0: begin
        a0  = int'($urandom_range(24000)) - 12000;
        a1  = int'($urandom_range(24000)) - 12000;
        a2  = int'($urandom_range(24000)) - 12000;
        b2  = int'($urandom_range(24000)) - 12000;
        lim = 16384 + b2 - 1000;
        b1  = int'($urandom_range(2 * lim)) - lim;
        off = int'($urandom_range(2000)) - 1000;
      end
      1: begin
        a0  = int'($urandom);
        a1  = int'($urandom);
        a2  = int'($urandom);
        b1  = int'($urandom);
        b2  = int'($urandom);
        off = int'($urandom);
      end
      default: begin
        a0  = $urandom_range(1) ? 131071 : -131072;
        a1  = $urandom_range(1) ? 131071 : -131072;
        a2  = $urandom_range(1) ? 131071 : -131072;
        b1  = $urandom_range(1) ? 131071 : -131072;
        b2  = $urandom_range(1) ? 131071 : -131072;
        off = $urandom_range(1) ? 32767 : -32768;
      end
    endcase
    load_coefs(18'(a0), 18'(a1), 18'(a2), 18'(b1), 18'(b2), 16'(off));
  endtask

  task automatic random_reqs(input int n);
    int                     r;
    logic [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      s = SAMPLE_BITS'($urandom);
      if ($urandom_range(9) == 0)
        s = $urandom_range(1) ? 16'h7fff : 16'h8000;
      if (r < 6)
        push_req(REQ_SOFT, s);
      else if (r < 9)
        push_req(REQ_CLEAR, s);
      else if (r < 11)
        push_req(REQ_UNUSED, s);
      else
        push_req(REQ_FILTER, s);
    end
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    int styles [0:8];
    styles = '{0, 1, 0, 2, 0, 1, 0, 0, 2};
    for (int i = 0; i < 6; i++) coef_q[i] = 0;
    src_idle_pct  = 22;
    sink_idle_pct = 85;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Rounding ties at the smallest gain, both signs.
    load_coefs(18'sd1, '0, '0, '0, '0, '0);
    push_req(REQ_FILTER, 16'sd8192);
    push_req(REQ_FILTER, -16'sd8192);
    push_req(REQ_FILTER, -16'sd24576);
    push_req(REQ_FILTER, 16'sd24576);
    settle();

    // Mixed gains: soft-reset ties, unused code, hard clear, sample extremes.
    load_coefs(18'sd16384, -18'sd8192, 18'sd4096, 18'sd8192, -18'sd4096, 16'sd100);
    write_reg(REG_UNMAPPED_LO, 18'h15555);
    write_reg(REG_UNMAPPED_HI, 18'h2aaaa);
    @(negedge clk);
    cfg_valid <= 1'b0;
    push_req(REQ_FILTER, 16'sd16384);
    push_req(REQ_FILTER, -16'sd16384);
    push_req(REQ_SOFT, 16'h0000);
    push_req(REQ_FILTER, 16'h0000);
    push_req(REQ_FILTER, 16'h0000);
    push_req(REQ_UNUSED, 16'sd12345);
    push_req(REQ_FILTER, 16'h0000);
    push_req(REQ_CLEAR, 16'hffff);
    push_req(REQ_FILTER, 16'h0000);
    push_req(REQ_FILTER, 16'h7fff);
    push_req(REQ_FILTER, 16'h8000);
    settle();

    // Extreme gains and offset: both saturation limits.
    load_coefs(18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071,
               16'sd32767);
    push_req(REQ_FILTER, 16'h7fff);
    push_req(REQ_FILTER, 16'h7fff);
    push_req(REQ_FILTER, 16'h8000);
    push_req(REQ_FILTER, 16'h8000);
    push_req(REQ_SOFT, 16'h0000);
    push_req(REQ_FILTER, 16'h0000);
    push_req(REQ_CLEAR, 16'h0000);
    push_req(REQ_FILTER, 16'h8000);
    push_req(REQ_FILTER, 16'h0001);
    settle();

    // Random phases: idle pattern changes every three phases.
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        src_idle_pct  = 85;
        sink_idle_pct = 22;
      end else if (p == 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      random_coefs(styles[p]);
      random_reqs(PHASE_ITEMS);
      if (p == 6) long_hold_pending = 1'b1;
      settle();
    end

    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/bqd_pkg.sv
rtl/biquad_iir_filter.sv
test/biquad_iir_filter_tb.sv
